### rtl/core/ppid_pkg.sv
// Shared widths, codes, limits and the configuration struct of the positional PID block.
// Used by ppid_regs, ppid_datapath and positional_pid_clamped_top.
package ppid_pkg;

    // data path widths
    localparam int DW       = 16;                  // Q8.8 data width
    localparam int FRAC_W   = 16;                  // gain fraction bits
    localparam int ERR_W    = DW + 1;              // error width
    localparam int DIFF_W   = ERR_W + 1;           // error difference width
    localparam int KP_W     = 19;
    localparam int KI_W     = 14;
    localparam int KD_W     = 13;
    localparam int ILIM_W   = DW - 1;
    localparam int PKP_W    = KP_W + 1 + ERR_W;    // kp * error
    localparam int PKI_W    = KI_W + 1 + ERR_W;    // ki * error
    localparam int PKD_W    = KD_W + 1 + DIFF_W;   // kd * difference
    localparam int INT_W    = DW + FRAC_W;         // integral width
    localparam int INTX_W   = INT_W + 1;           // integral before clamp
    localparam int SUM_W    = PKP_W + 2;           // total sum
    localparam int SHR_W    = SUM_W - FRAC_W;      // sum after floor shift
    localparam int TDATA_W  = ((DW + 7) / 8) * 8;

    // configuration port
    localparam int ADDR_W   = 5;
    localparam int PDATA_W  = 32;
    localparam int IDX_W    = ADDR_W - 2;

    localparam logic [KP_W-1:0] KP_MAX = KP_W'(327680);
    localparam logic [KI_W-1:0] KI_MAX = KI_W'(13107);
    localparam logic [KD_W-1:0] KD_MAX = KD_W'(6553);

    // register indexes
    localparam logic [IDX_W-1:0] REG_TARGET = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_KP     = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_KI     = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_KD     = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_UPPER  = IDX_W'(4);
    localparam logic [IDX_W-1:0] REG_LOWER  = IDX_W'(5);
    localparam logic [IDX_W-1:0] REG_ILIM   = IDX_W'(6);

    // item kinds
    localparam logic CMD_COMPUTE = 1'b0;
    localparam logic CMD_CLEAR   = 1'b1;

    typedef struct packed {
        logic [DW-1:0]     target;
        logic [KP_W-1:0]   kp;
        logic [KI_W-1:0]   ki;
        logic [KD_W-1:0]   kd;
        logic [DW-1:0]     upper;
        logic [DW-1:0]     lower;
        logic [ILIM_W-1:0] ilim;
    } t_cfg;

endpackage

### rtl/core/positional_pid_clamped_top.sv
// Positional PID controller with a clamped integral (anti-windup) and a clamped drive.
// A word (cmd in tuser, Q8.8 measurement in tdata) is taken into an input register,
// worked out in one pass of combinational logic and stored in an output register, so
// the block takes one word per cycle when the output side does not stall and answers
// each from the output register. Integral and previous error update as the word leaves
// the input register; a clear word zeroes both and answers lower_limit. Gains and
// limits sit in APB registers the user writes while no word is in flight, unenforced.
module positional_pid_clamped_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [ppid_pkg::TDATA_W-1:0]     i_s_tdata,  // [15:0] measurement
    input  logic                             i_s_tuser,  // [0] cmd
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [ppid_pkg::TDATA_W-1:0]     o_m_tdata,  // [15:0] drive
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ppid_pkg::ADDR_W-1:0]      paddr,
    input  logic [ppid_pkg::PDATA_W-1:0]     pwdata,
    output logic [ppid_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready
);

    ppid_pkg::t_cfg              cfg;
    logic                        r_in_valid;
    logic                        r_in_cmd;
    logic [ppid_pkg::DW-1:0]     r_in_meas;
    logic                        r_out_valid;
    logic [ppid_pkg::DW-1:0]     r_out_drive;
    logic [ppid_pkg::DW-1:0]     drive;
    logic                        out_free;
    logic                        advance;
    logic                        in_take;

    ppid_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ppid_datapath u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_advance (advance),
        .i_cmd     (r_in_cmd),
        .i_meas    (r_in_meas),
        .o_drive   (drive)
    );

    assign out_free   = !r_out_valid | i_m_tready;
    assign advance    = r_in_valid & out_free;
    assign o_s_tready = !r_in_valid | out_free;
    assign in_take    = i_s_tvalid & o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // input register refills or drains
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_cmd  <= i_s_tuser;
            r_in_meas <= i_s_tdata[ppid_pkg::DW-1:0];
        end
        if (advance) begin
            r_out_drive <= drive;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = ppid_pkg::TDATA_W'(r_out_drive);

endmodule

### rtl/core/ppid_regs.sv
// APB-style configuration registers of the positional PID block.
// Depends on ppid_pkg for widths, register indexes and gain limits.
module ppid_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ppid_pkg::ADDR_W-1:0] paddr,
    input  logic [ppid_pkg::PDATA_W-1:0] pwdata,
    output logic [ppid_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output ppid_pkg::t_cfg              o_cfg
);

    ppid_pkg::t_cfg                r_cfg;
    logic [ppid_pkg::IDX_W-1:0]    idx;
    logic                          wr_en;
    logic [ppid_pkg::KP_W-1:0]     kp_raw;
    logic [ppid_pkg::KI_W-1:0]     ki_raw;
    logic [ppid_pkg::KD_W-1:0]     kd_raw;

    assign idx    = paddr[ppid_pkg::ADDR_W-1:2];
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign kp_raw = pwdata[ppid_pkg::KP_W-1:0];
    assign ki_raw = pwdata[ppid_pkg::KI_W-1:0];
    assign kd_raw = pwdata[ppid_pkg::KD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target <= '0;
            r_cfg.kp     <= '0;
            r_cfg.ki     <= '0;
            r_cfg.kd     <= '0;
            r_cfg.upper  <= {1'b0, {(ppid_pkg::DW-1){1'b1}}};
            r_cfg.lower  <= {1'b1, {(ppid_pkg::DW-1){1'b0}}};
            r_cfg.ilim   <= '1;
        end else if (wr_en) begin
            unique case (idx)
                ppid_pkg::REG_TARGET: r_cfg.target <= pwdata[ppid_pkg::DW-1:0];
                // saturate gains to their maximum
                ppid_pkg::REG_KP: r_cfg.kp <= (kp_raw > ppid_pkg::KP_MAX) ?
                                              ppid_pkg::KP_MAX : kp_raw;
                ppid_pkg::REG_KI: r_cfg.ki <= (ki_raw > ppid_pkg::KI_MAX) ?
                                              ppid_pkg::KI_MAX : ki_raw;
                ppid_pkg::REG_KD: r_cfg.kd <= (kd_raw > ppid_pkg::KD_MAX) ?
                                              ppid_pkg::KD_MAX : kd_raw;
                ppid_pkg::REG_UPPER: r_cfg.upper <= pwdata[ppid_pkg::DW-1:0];
                ppid_pkg::REG_LOWER: r_cfg.lower <= pwdata[ppid_pkg::DW-1:0];
                ppid_pkg::REG_ILIM:  r_cfg.ilim  <= pwdata[ppid_pkg::ILIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            ppid_pkg::REG_TARGET: prdata = ppid_pkg::PDATA_W'(r_cfg.target);
            ppid_pkg::REG_KP:     prdata = ppid_pkg::PDATA_W'(r_cfg.kp);
            ppid_pkg::REG_KI:     prdata = ppid_pkg::PDATA_W'(r_cfg.ki);
            ppid_pkg::REG_KD:     prdata = ppid_pkg::PDATA_W'(r_cfg.kd);
            ppid_pkg::REG_UPPER:  prdata = ppid_pkg::PDATA_W'(r_cfg.upper);
            ppid_pkg::REG_LOWER:  prdata = ppid_pkg::PDATA_W'(r_cfg.lower);
            ppid_pkg::REG_ILIM:   prdata = ppid_pkg::PDATA_W'(r_cfg.ilim);
            default:              prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/core/ppid_datapath.sv
// Single-pass PID arithmetic with the integral and previous-error state registers.
// Depends on ppid_pkg for widths, command codes and the configuration struct.
module ppid_datapath (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ppid_pkg::t_cfg         i_cfg,
    input  logic                   i_advance,
    input  logic                   i_cmd,
    input  logic [ppid_pkg::DW-1:0] i_meas,
    output logic [ppid_pkg::DW-1:0] o_drive
);

    logic signed [ppid_pkg::ERR_W-1:0]  r_prev_err;
    logic signed [ppid_pkg::INT_W-1:0]  r_integ;
    logic signed [ppid_pkg::ERR_W-1:0]  n_prev_err;
    logic signed [ppid_pkg::INT_W-1:0]  n_integ;

    logic signed [ppid_pkg::ERR_W-1:0]  err;
    logic signed [ppid_pkg::DIFF_W-1:0] diff;
    logic signed [ppid_pkg::PKP_W-1:0]  p_prod;
    logic signed [ppid_pkg::PKI_W-1:0]  i_prod;
    logic signed [ppid_pkg::PKD_W-1:0]  d_prod;
    logic signed [ppid_pkg::INTX_W-1:0] integ_raw;
    logic signed [ppid_pkg::INTX_W-1:0] ilim_pos;
    logic signed [ppid_pkg::INTX_W-1:0] ilim_neg;
    logic signed [ppid_pkg::INT_W-1:0]  integ_clamped;
    logic signed [ppid_pkg::SUM_W-1:0]  sum;
    logic signed [ppid_pkg::SHR_W-1:0]  sum_q;
    logic signed [ppid_pkg::SHR_W-1:0]  upper_x;
    logic signed [ppid_pkg::SHR_W-1:0]  lower_x;
    logic [ppid_pkg::DW-1:0]            drive_calc;

    assign err  = ppid_pkg::ERR_W'($signed(i_cfg.target)) - ppid_pkg::ERR_W'($signed(i_meas));
    assign diff = ppid_pkg::DIFF_W'(err) - ppid_pkg::DIFF_W'(r_prev_err);

    assign p_prod = $signed({1'b0, i_cfg.kp}) * err;
    assign i_prod = $signed({1'b0, i_cfg.ki}) * err;
    assign d_prod = $signed({1'b0, i_cfg.kd}) * diff;

    // integral is exact before the clamp
    assign integ_raw = ppid_pkg::INTX_W'(r_integ) + ppid_pkg::INTX_W'(i_prod);
    assign ilim_pos  = $signed({2'b00, i_cfg.ilim, {ppid_pkg::FRAC_W{1'b0}}});
    assign ilim_neg  = -ilim_pos;

    always_comb begin
        priority if (integ_raw > ilim_pos) begin
            integ_clamped = ilim_pos[ppid_pkg::INT_W-1:0];
        end else if (integ_raw < ilim_neg) begin
            integ_clamped = ilim_neg[ppid_pkg::INT_W-1:0];
        end else begin
            integ_clamped = integ_raw[ppid_pkg::INT_W-1:0];
        end
    end

    assign sum = ppid_pkg::SUM_W'(p_prod) + ppid_pkg::SUM_W'(integ_clamped)
               + ppid_pkg::SUM_W'(d_prod);
    // floor toward minus infinity
    assign sum_q   = sum[ppid_pkg::SUM_W-1:ppid_pkg::FRAC_W];
    assign upper_x = ppid_pkg::SHR_W'($signed(i_cfg.upper));
    assign lower_x = ppid_pkg::SHR_W'($signed(i_cfg.lower));

    // upper bound wins when the limits cross
    always_comb begin
        priority if (sum_q > upper_x) begin
            drive_calc = i_cfg.upper;
        end else if (sum_q < lower_x) begin
            drive_calc = i_cfg.lower;
        end else begin
            drive_calc = sum_q[ppid_pkg::DW-1:0];
        end
    end

    always_comb begin
        unique case (i_cmd)
            ppid_pkg::CMD_CLEAR: begin
                n_prev_err = '0;
                n_integ    = '0;
                o_drive    = i_cfg.lower;
            end
            default: begin
                n_prev_err = err;
                n_integ    = integ_clamped;
                o_drive    = drive_calc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err <= '0;
            r_integ    <= '0;
        end else if (i_advance) begin
            r_prev_err <= n_prev_err;
            r_integ    <= n_integ;
        end
    end

endmodule

### dv/ppid_checker.sv
`timescale 1ns / 1ps
// Scoreboard for positional_pid_clamped_top: mirrors the APB registers, predicts the drive
// of every accepted input word and compares it with the output stream.
// Depends on ppid_pkg for widths, register indexes, item kinds and gain limits.
module ppid_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [ppid_pkg::TDATA_W-1:0]  i_s_tdata,  // [15:0] measurement
    input  logic                          i_s_tuser,  // [0] cmd
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [ppid_pkg::TDATA_W-1:0]  i_m_tdata,  // [15:0] drive
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [ppid_pkg::ADDR_W-1:0]   i_paddr,
    input  logic [ppid_pkg::PDATA_W-1:0]  i_pwdata,
    input  logic [ppid_pkg::PDATA_W-1:0]  i_prdata,
    input  logic                          i_pready,
    output int                            o_fail_count,
    output int                            o_pending
);
    import ppid_pkg::*;

    t_cfg                     cfg;
    logic signed [ERR_W-1:0]  last_err;
    logic signed [INT_W-1:0]  integ_acc;
    logic [DW-1:0]            drive_q[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        o_fail_count++;
    endtask

    // One control step; updates the integral and error history.
    function automatic logic [DW-1:0] pid_drive(input logic cmd, input logic [DW-1:0] meas);
        longint err;
        longint ilim;
        longint integ;
        longint sum;
        longint drv;
        longint hi;
        longint lo;
        if (cmd == CMD_CLEAR) begin
            integ_acc = '0;
            last_err  = '0;
            return cfg.lower;
        end
        err   = longint'($signed(cfg.target)) - longint'($signed(meas));
        ilim  = longint'(cfg.ilim) * 65536;
        integ = longint'(integ_acc) + longint'(cfg.ki) * err;
        if (integ > ilim)
            integ = ilim;
        else if (integ < -ilim)
            integ = -ilim;
        integ_acc = integ[INT_W-1:0];
        sum = longint'(cfg.kp) * err + integ + longint'(cfg.kd) * (err - longint'(last_err));
        last_err = err[ERR_W-1:0];
        // arithmetic shift floors toward minus infinity
        drv = sum >>> FRAC_W;
        hi  = longint'($signed(cfg.upper));
        lo  = longint'($signed(cfg.lower));
        // upper bound wins when the limits are crossed
        if (drv > hi)
            drv = hi;
        else if (drv < lo)
            drv = lo;
        return drv[DW-1:0];
    endfunction

    always @(posedge i_clk) begin : watch
        logic [DW-1:0]        want;
        logic [IDX_W-1:0]     idx;
        logic [PDATA_W-1:0]   rd_want;
        logic [PDATA_W-1:0]   rd_mask;
        int                   rd_w;
        if (!i_rst_n) begin
            cfg.target = '0;
            cfg.kp     = '0;
            cfg.ki     = '0;
            cfg.kd     = '0;
            cfg.upper  = {1'b0, {(DW-1){1'b1}}};
            cfg.lower  = {1'b1, {(DW-1){1'b0}}};
            cfg.ilim   = '1;
            last_err   = '0;
            integ_acc  = '0;
            drive_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                drive_q.push_back(pid_drive(i_s_tuser, i_s_tdata[DW-1:0]));
            if (i_m_tvalid && i_m_tready) begin
                if (drive_q.size() == 0) begin
                    report_mismatch($sformatf("drive %h with nothing expected",
                                              i_m_tdata[DW-1:0]));
                end else begin
                    want = drive_q.pop_front();
                    if (i_m_tdata[DW-1:0] !== want)
                        report_mismatch($sformatf("drive %h, expected %h",
                                                  i_m_tdata[DW-1:0], want));
                end
            end
            if (i_psel && i_penable && i_pready) begin
                idx = i_paddr[ADDR_W-1:2];
                if (i_pwrite) begin
                    case (idx)
                        REG_TARGET: cfg.target = i_pwdata[DW-1:0];
                        REG_KP: cfg.kp = (i_pwdata[KP_W-1:0] > KP_MAX) ? KP_MAX
                                                                       : i_pwdata[KP_W-1:0];
                        REG_KI: cfg.ki = (i_pwdata[KI_W-1:0] > KI_MAX) ? KI_MAX
                                                                       : i_pwdata[KI_W-1:0];
                        REG_KD: cfg.kd = (i_pwdata[KD_W-1:0] > KD_MAX) ? KD_MAX
                                                                       : i_pwdata[KD_W-1:0];
                        REG_UPPER:  cfg.upper = i_pwdata[DW-1:0];
                        REG_LOWER:  cfg.lower = i_pwdata[DW-1:0];
                        REG_ILIM:   cfg.ilim  = i_pwdata[ILIM_W-1:0];
                        default: ;
                    endcase
                end else begin
                    rd_want = '0;
                    rd_w    = 0;
                    case (idx)
                        REG_TARGET: begin rd_want = PDATA_W'(cfg.target); rd_w = DW;     end
                        REG_KP:     begin rd_want = PDATA_W'(cfg.kp);     rd_w = KP_W;   end
                        REG_KI:     begin rd_want = PDATA_W'(cfg.ki);     rd_w = KI_W;   end
                        REG_KD:     begin rd_want = PDATA_W'(cfg.kd);     rd_w = KD_W;   end
                        REG_UPPER:  begin rd_want = PDATA_W'(cfg.upper);  rd_w = DW;     end
                        REG_LOWER:  begin rd_want = PDATA_W'(cfg.lower);  rd_w = DW;     end
                        REG_ILIM:   begin rd_want = PDATA_W'(cfg.ilim);   rd_w = ILIM_W; end
                        default: ;
                    endcase
                    rd_mask = (PDATA_W'(1) << rd_w) - PDATA_W'(1);
                    if ((i_prdata & rd_mask) !== rd_want)
                        report_mismatch($sformatf("register %0d reads %h, expected %h",
                                                  idx, i_prdata & rd_mask, rd_want));
                end
            end
        end
        o_pending = drive_q.size();
    end

endmodule

### dv/tb_positional_pid_clamped_top.sv
`timescale 1ns / 1ps
// Top of the positional PID testbench: directed and random words and register settings
// under several idle/stall mixes. Needs ppid_pkg, positional_pid_clamped_top, ppid_checker.
module tb_positional_pid_clamped_top;
    import ppid_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int BLOCK_WORDS = 54;
    localparam logic [IDX_W-1:0] REG_NONE = IDX_W'(7);

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [TDATA_W-1:0]  s_tdata  = '0;
    logic                s_tuser  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [ADDR_W-1:0]   paddr    = '0;
    logic [PDATA_W-1:0]  pwdata   = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    int                  fail_count;
    int                  pending;
    int                  idle_pct  = 0;
    int                  stall_pct = 0;
    int                  quiet_cycles = 0;
    logic [DW-1:0]       cur_target = '0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    positional_pid_clamped_top uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    ppid_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    // End the run when nothing moves for too long.
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic apb_access(input logic wr, input logic [IDX_W-1:0] idx,
                              input logic [PDATA_W-1:0] data);
        logic done;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do begin
            @(negedge clk);
            done = pready;
            @(posedge clk);
        end while (!done);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_word(input logic cmd, input logic [DW-1:0] meas);
        logic took;
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= TDATA_W'(meas);
        do begin
            @(negedge clk);
            took = s_tready;
            @(posedge clk);
        end while (!took);
    endtask

    // Hold the input until every expected drive has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    task automatic settle();
        drain();
        repeat (4) @(posedge clk);
    endtask

    task automatic set_target(input logic [PDATA_W-1:0] v);
        apb_access(1'b1, REG_TARGET, v);
        cur_target = v[DW-1:0];
    endtask

    task automatic random_config();
        logic [DW-1:0] lo;
        logic [DW-1:0] hi;
        logic [DW-1:0] t;
        case ($urandom_range(3))
            0:       set_target(32'h0000_8000);
            1:       set_target(32'h0000_7FFF);
            default: set_target($urandom);
        endcase
        case ($urandom_range(3))
            0:       apb_access(1'b1, REG_KP, '0);
            1:       apb_access(1'b1, REG_KP, PDATA_W'(KP_MAX));
            2:       apb_access(1'b1, REG_KP, $urandom);
            default: apb_access(1'b1, REG_KP, $urandom_range(0, 32768));
        endcase
        case ($urandom_range(3))
            0:       apb_access(1'b1, REG_KI, '0);
            1:       apb_access(1'b1, REG_KI, PDATA_W'(KI_MAX));
            2:       apb_access(1'b1, REG_KI, $urandom);
            default: apb_access(1'b1, REG_KI, $urandom_range(0, 2000));
        endcase
        case ($urandom_range(3))
            0:       apb_access(1'b1, REG_KD, '0);
            1:       apb_access(1'b1, REG_KD, PDATA_W'(KD_MAX));
            2:       apb_access(1'b1, REG_KD, $urandom);
            default: apb_access(1'b1, REG_KD, $urandom_range(0, 1000));
        endcase
        lo = DW'($urandom);
        hi = DW'($urandom);
        if ($urandom_range(5) == 0) begin
            lo = 16'h8000;
            hi = 16'h7FFF;
        end else if ($urandom_range(4) != 0 && $signed(lo) > $signed(hi)) begin
            t  = lo;
            lo = hi;
            hi = t;
        end
        apb_access(1'b1, REG_UPPER, PDATA_W'(hi) | ($urandom & 32'hFFFF_0000));
        apb_access(1'b1, REG_LOWER, PDATA_W'(lo));
        case ($urandom_range(2))
            0:       apb_access(1'b1, REG_ILIM, '0);
            1:       apb_access(1'b1, REG_ILIM, 32'h0000_7FFF);
            default: apb_access(1'b1, REG_ILIM, $urandom);
        endcase
    endtask

    task automatic send_random();
        logic [DW-1:0] meas;
        logic          cmd;
        cmd = ($urandom_range(99) < 6) ? CMD_CLEAR : CMD_COMPUTE;
        case ($urandom_range(9))
            0: meas = DW'($urandom);
            1: case ($urandom_range(3))
                   0:       meas = 16'h8000;
                   1:       meas = 16'h7FFF;
                   2:       meas = 16'h0000;
                   default: meas = 16'hFFFF;
               endcase
            default: meas = cur_target + DW'($urandom_range(0, 2047)) - DW'(1024);
        endcase
        send_word(cmd, meas);
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: all gains zero
        send_word(CMD_COMPUTE, 16'h8000);
        settle();

        // gains written above their maximum saturate; small integral bound
        set_target(32'h0000_1000);
        apb_access(1'b1, REG_KP, 32'hFFFF_FFFF);
        apb_access(1'b1, REG_KI, 32'h0000_FFFF);
        apb_access(1'b1, REG_KD, 32'h0000_1FFF);
        apb_access(1'b1, REG_ILIM, 32'h0000_0100);
        apb_access(1'b1, REG_NONE, 32'h0000_1234);
        for (int r = 0; r < 7; r++)
            apb_access(1'b0, IDX_W'(r), '0);
        send_word(CMD_COMPUTE, 16'h8000);
        send_word(CMD_COMPUTE, 16'h7FFF);
        send_word(CMD_COMPUTE, 16'h0000);
        send_word(CMD_COMPUTE, 16'hFFFF);
        send_word(CMD_COMPUTE, 16'h8000);
        send_word(CMD_COMPUTE, 16'h8000);
        send_word(CMD_CLEAR,   16'hA5A5);
        send_word(CMD_COMPUTE, 16'h7FFF);
        send_word(CMD_COMPUTE, 16'h0001);
        settle();

        // crossed limits, odd gains so the floor of negative sums shows
        set_target(32'h0000_8000);
        apb_access(1'b1, REG_KP, 32'd12345);
        apb_access(1'b1, REG_KI, 32'd1);
        apb_access(1'b1, REG_KD, PDATA_W'(KD_MAX));
        apb_access(1'b1, REG_UPPER, 32'h0000_0100);
        apb_access(1'b1, REG_LOWER, 32'h0000_0400);
        apb_access(1'b1, REG_ILIM, 32'h0000_7FFF);
        send_word(CMD_COMPUTE, 16'h8001);
        send_word(CMD_COMPUTE, 16'h7FFF);
        send_word(CMD_COMPUTE, 16'h8000);
        send_word(CMD_CLEAR,   16'h5A5A);
        send_word(CMD_COMPUTE, 16'h0200);
        send_word(CMD_COMPUTE, 16'hFF00);
        send_word(CMD_COMPUTE, 16'h1234);
        settle();

        // largest error, integral pinned at zero
        set_target(32'h0000_7FFF);
        apb_access(1'b1, REG_KP, '0);
        apb_access(1'b1, REG_KI, PDATA_W'(KI_MAX));
        apb_access(1'b1, REG_KD, '0);
        apb_access(1'b1, REG_UPPER, 32'h0000_7FFF);
        apb_access(1'b1, REG_LOWER, 32'h0000_8000);
        apb_access(1'b1, REG_ILIM, '0);
        send_word(CMD_COMPUTE, 16'h8000);
        send_word(CMD_COMPUTE, 16'h8000);
        send_word(CMD_CLEAR,   16'hFFFF);
        send_word(CMD_COMPUTE, 16'h7FFF);
        send_word(CMD_COMPUTE, 16'h0000);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 60; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 60; end
                default: begin idle_pct = 37; stall_pct = 37; end
            endcase
            for (int blk = 0; blk < 3; blk++) begin
                settle();
                random_config();
                for (int n = 0; n < BLOCK_WORDS; n++) begin
                    if (n == BLOCK_WORDS / 2)
                        drain();
                    send_random();
                end
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### positional_pid_clamped_top.f
rtl/core/ppid_pkg.sv
rtl/core/ppid_regs.sv
rtl/core/ppid_datapath.sv
rtl/core/positional_pid_clamped_top.sv
dv/ppid_checker.sv
dv/tb_positional_pid_clamped_top.sv
